@@ hw/rtl/imne_pkg.sv @@
// imne_pkg: widths, constants, ratio table and controller/datapath structs
// for the interval mask note expander. No dependencies.
package imne_pkg;

    // Design constants
    localparam int MAX_OCTAVES     = 4;
    localparam int RATIO_FRAC_BITS = 16;

    // Request field widths
    localparam int IN_MASK_W  = 16;
    localparam int IN_ROOT_W  = 24;
    localparam int IN_PITCH_W = 4;
    localparam int IN_NOCT_W  = 3;

    // Note field widths
    localparam int OUT_IDX_W   = 6;
    localparam int OUT_PITCH_W = 4;
    localparam int OUT_SEMI_W  = 6;
    localparam int OUT_FREQ_W  = 28;

    // Scan positions inside the mask
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] BIT_FIRST  = 4'd15;  // unison
    localparam logic [POS_W-1:0] BIT_REPEAT = 4'd14;  // first bit of later octaves
    localparam logic [POS_W-1:0] BIT_LAST   = 4'd3;   // octave
    localparam int SEMIS_PER_OCT = 12;

    localparam int OCT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

    // Arithmetic widths
    localparam int RATIO_W   = RATIO_FRAC_BITS + 2;            // ratio up to 2.0
    localparam int PROD_W    = IN_ROOT_W + RATIO_W;
    localparam int SHIFT_EXT = MAX_OCTAVES + 2;                // octave shift headroom
    localparam int FULL_W    = PROD_W + SHIFT_EXT - RATIO_FRAC_BITS;
    localparam logic [OUT_FREQ_W-1:0] FREQ_MAX = {OUT_FREQ_W{1'b1}};

    // 2^(s/12) in Q24, rounded to nearest
    localparam int Q24_W = 26;
    localparam logic [Q24_W-1:0] RATIO_Q24 [13] = '{
        26'd16777216, 26'd17774841, 26'd18831788, 26'd19951585, 26'd21137968,
        26'd22394897, 26'd23726566, 26'd25137421, 26'd26632170, 26'd28215802,
        26'd29893600, 26'd31671166, 26'd33554432
    };

    // Q24 entry reduced to RATIO_FRAC_BITS, round half up
    function automatic logic [RATIO_W-1:0] ratio_at(input logic [POS_W-1:0] semi);
        logic [Q24_W+1:0] w;
        w = ({1'b0, RATIO_Q24[semi], 1'b0} >> (24 - RATIO_FRAC_BITS)) + (Q24_W+2)'(1);
        return w[RATIO_W:1];
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic             load_req;
        logic             capture;
        logic             load_out;
        logic [POS_W-1:0] pos;
        logic [OCT_W-1:0] oct;
    } t_dp_cmd;

    typedef struct packed {
        logic req_ok;       // incoming request yields at least one note
        logic bit_set;      // mask bit at cmd.pos is set
        logic more_oct;     // an octave follows cmd.oct
        logic out_free;     // output register can take a note
        logic last_pending; // captured note is the final one
    } t_dp_sts;

endpackage

@@ hw/rtl/imne_if.sv @@
// imne_if: valid/ready channel interfaces for requests and notes.
// Depends on imne_pkg.
interface imne_req_if
    import imne_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [IN_MASK_W-1:0]  interval_mask;
    logic [IN_ROOT_W-1:0]  root_freq;
    logic [IN_PITCH_W-1:0] root_pitch;
    logic [IN_NOCT_W-1:0]  octave_count;

    modport source (output valid, interval_mask, root_freq, root_pitch, octave_count,
                    input ready);
    modport sink   (input valid, interval_mask, root_freq, root_pitch, octave_count,
                    output ready);
endinterface

interface imne_note_if
    import imne_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OUT_IDX_W-1:0]   note_index;
    logic [OUT_PITCH_W-1:0] pitch_class;
    logic [OUT_SEMI_W-1:0]  semitone_above_root;
    logic [OUT_FREQ_W-1:0]  note_freq;
    logic                   last_note;

    modport source (output valid, note_index, pitch_class, semitone_above_root,
                    note_freq, last_note, input ready);
    modport sink   (input valid, note_index, pitch_class, semitone_above_root,
                    note_freq, last_note, output ready);
endinterface

@@ hw/rtl/imne_ctrl.sv @@
// imne_ctrl: scan sequencer (mask bit position, octave) for the note expander.
// Depends on imne_pkg; drives imne_dp through t_dp_cmd.
module imne_ctrl
    import imne_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [OCT_W-1:0] r_oct, n_oct;

    logic             w_adv_done;
    logic [POS_W-1:0] w_adv_pos;
    logic [OCT_W-1:0] w_adv_oct;

    // next scan position: down one bit, or wrap into the next octave
    always_comb begin
        w_adv_done = (r_pos == BIT_LAST) && !i_sts.more_oct;
        if (r_pos == BIT_LAST) begin
            w_adv_pos = BIT_REPEAT;
            w_adv_oct = r_oct + OCT_W'(1);
        end else begin
            w_adv_pos = r_pos - POS_W'(1);
            w_adv_oct = r_oct;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        n_oct          = r_oct;
        o_cmd          = '0;
        o_cmd.pos      = r_pos;
        o_cmd.oct      = r_oct;
        o_req_ready    = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    if (i_sts.req_ok) begin
                        n_state = ST_SCAN;
                        n_pos   = BIT_FIRST;
                        n_oct   = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.bit_set) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EMIT;
                end else if (w_adv_done) begin
                    n_state = ST_IDLE;
                end else begin
                    n_pos = w_adv_pos;
                    n_oct = w_adv_oct;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.last_pending || w_adv_done) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_SCAN;
                        n_pos   = w_adv_pos;
                        n_oct   = w_adv_oct;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_oct   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_oct   <= n_oct;
        end
    end

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_sts.out_free) |=> (r_state == ST_EMIT))
        else $error("note dropped while output stalled");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_pos >= BIT_LAST))
        else $error("scan position below octave bit");

    a_empty_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_req_valid && !i_sts.req_ok) |=> (r_state == ST_IDLE))
        else $error("empty request started a scan");

endmodule

@@ hw/rtl/imne_dp.sv @@
// imne_dp: request registers, ratio multiply and note output register.
// Depends on imne_pkg; commanded by imne_ctrl.
module imne_dp
    import imne_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [IN_MASK_W-1:0]   i_interval_mask,
    input  logic [IN_ROOT_W-1:0]   i_root_freq,
    input  logic [IN_PITCH_W-1:0]  i_root_pitch,
    input  logic [IN_NOCT_W-1:0]   i_octave_count,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_IDX_W-1:0]   o_note_index,
    output logic [OUT_PITCH_W-1:0] o_pitch_class,
    output logic [OUT_SEMI_W-1:0]  o_semitone_above_root,
    output logic [OUT_FREQ_W-1:0]  o_note_freq,
    output logic                   o_last_note
);

    // request
    logic [IN_MASK_W-1:0]   r_mask;
    logic [IN_ROOT_W-1:0]   r_root;
    logic [IN_PITCH_W-1:0]  r_pitch;
    logic [IN_NOCT_W-1:0]   r_noct;
    logic [OUT_IDX_W-1:0]   r_idx;
    // capture stage
    logic [PROD_W-1:0]      r_prod;
    logic [OCT_W-1:0]       r_c_oct;
    logic [OUT_PITCH_W-1:0] r_c_pitch;
    logic [OUT_SEMI_W-1:0]  r_c_semi;
    logic                   r_c_last;
    // output register
    logic                   r_out_valid;
    logic [OUT_IDX_W-1:0]   r_o_idx;
    logic [OUT_PITCH_W-1:0] r_o_pitch;
    logic [OUT_SEMI_W-1:0]  r_o_semi;
    logic [OUT_FREQ_W-1:0]  r_o_freq;
    logic                   r_o_last;

    logic [POS_W-1:0]          w_semi;
    logic [RATIO_W-1:0]        w_ratio;
    logic [PROD_W-1:0]         w_prod;
    logic [4:0]                w_psum;
    logic [OUT_PITCH_W-1:0]    w_pclass;
    logic                      w_rem_cur;
    logic                      w_any_later;
    logic [PROD_W+SHIFT_EXT-1:0] w_shift;
    logic [FULL_W-1:0]         w_full;
    logic [OUT_FREQ_W-1:0]     w_freq;
    logic                      w_out_free;

    assign w_semi  = BIT_FIRST - i_cmd.pos;
    assign w_ratio = ratio_at(w_semi);
    assign w_prod  = {{RATIO_W{1'b0}}, r_root} * {{IN_ROOT_W{1'b0}}, w_ratio};

    // (root + s) mod 12, sum stays below 36
    always_comb begin
        w_psum = 5'(r_pitch) + 5'(w_semi);
        if (w_psum >= 5'(2 * SEMIS_PER_OCT)) begin
            w_pclass = OUT_PITCH_W'(w_psum - 5'(2 * SEMIS_PER_OCT));
        end else if (w_psum >= 5'(SEMIS_PER_OCT)) begin
            w_pclass = OUT_PITCH_W'(w_psum - 5'(SEMIS_PER_OCT));
        end else begin
            w_pclass = OUT_PITCH_W'(w_psum);
        end
    end

    // set bits left below the current position in this octave
    always_comb begin
        w_rem_cur = 1'b0;
        for (int i = int'(BIT_LAST); i < int'(BIT_FIRST); i++) begin
            if (POS_W'(i) < i_cmd.pos && r_mask[i]) begin
                w_rem_cur = 1'b1;
            end
        end
    end

    assign w_any_later = |r_mask[BIT_REPEAT:BIT_LAST];

    assign o_sts.req_ok       = (|i_interval_mask[BIT_FIRST:BIT_LAST]) &&
                                (i_octave_count != '0);
    assign o_sts.bit_set      = r_mask[i_cmd.pos];
    assign o_sts.more_oct     = (IN_NOCT_W'(i_cmd.oct) + IN_NOCT_W'(1)) < r_noct;
    assign w_out_free         = !r_out_valid || i_ready;
    assign o_sts.out_free     = w_out_free;
    assign o_sts.last_pending = r_c_last;

    // octave shift, drop fraction, saturate
    assign w_shift = {{SHIFT_EXT{1'b0}}, r_prod} << r_c_oct;
    assign w_full  = w_shift[PROD_W+SHIFT_EXT-1:RATIO_FRAC_BITS];
    assign w_freq  = (|w_full[FULL_W-1:OUT_FREQ_W]) ? FREQ_MAX : w_full[OUT_FREQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mask  <= i_interval_mask;
            r_root  <= i_root_freq;
            r_pitch <= i_root_pitch;
            r_noct  <= (i_octave_count > IN_NOCT_W'(MAX_OCTAVES)) ?
                       IN_NOCT_W'(MAX_OCTAVES) : i_octave_count;
        end
        if (i_cmd.capture) begin
            r_prod    <= w_prod;
            r_c_oct   <= i_cmd.oct;
            r_c_pitch <= w_pclass;
            r_c_semi  <= OUT_SEMI_W'(i_cmd.oct) * OUT_SEMI_W'(SEMIS_PER_OCT) +
                         OUT_SEMI_W'(w_semi);
            r_c_last  <= !(w_rem_cur || (o_sts.more_oct && w_any_later));
        end
        if (i_cmd.load_out) begin
            r_o_idx   <= r_idx;
            r_o_pitch <= r_c_pitch;
            r_o_semi  <= r_c_semi;
            r_o_freq  <= w_freq;
            r_o_last  <= r_c_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_req) begin
                r_idx <= '0;
            end else if (i_cmd.load_out) begin
                r_idx <= r_idx + OUT_IDX_W'(1);
            end
        end
    end

    assign o_valid               = r_out_valid;
    assign o_note_index          = r_o_idx;
    assign o_pitch_class         = r_o_pitch;
    assign o_semitone_above_root = r_o_semi;
    assign o_note_freq           = r_o_freq;
    assign o_last_note           = r_o_last;

    a_capture_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> r_mask[i_cmd.pos])
        else $error("capture on a clear mask bit");

    a_last_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_c_last) |=> (r_out_valid && r_o_last))
        else $error("final note not presented");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_o_freq) &&
                                       $stable(r_o_idx) && $stable(r_o_last)))
        else $error("stalled note changed");

endmodule

@@ hw/rtl/interval_mask_note_expander.sv @@
// interval_mask_note_expander: top level, expands an interval mask request
// into notes. Depends on imne_pkg, imne_if, imne_ctrl, imne_dp.
//
//  channel  dir  handshake            payload
//  i_req    in   valid/ready (sink)   interval_mask, root_freq, root_pitch,
//                                     octave_count
//  o_note   out  valid/ready (source) note_index, pitch_class,
//                                     semitone_above_root, note_freq, last_note
//
// A request is taken while idle; the scan then covers one mask position per cycle
// (13 in the first octave, 12 in each later one), except that each note adds an
// emit step for the root-times-ratio result, held while o_note is stalled.
// i_clk is the only clock; i_rst_n is synchronous, active low, and leaves the
// block idle with no note pending. A stalled o_note holds the scan on the
// note being emitted; the next request is taken as soon as the last note of
// the current one sits in the output register.
module interval_mask_note_expander
    import imne_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    imne_req_if.sink   i_req,
    imne_note_if.source o_note
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_req_ready;

    // sequencer: walks the mask bit by bit across the octaves
    imne_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_req_ready;

    // datapath: holds the request, multiplies, shifts and presents notes
    imne_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_sts                 (w_sts),
        .i_interval_mask       (i_req.interval_mask),
        .i_root_freq           (i_req.root_freq),
        .i_root_pitch          (i_req.root_pitch),
        .i_octave_count        (i_req.octave_count),
        .o_valid               (o_note.valid),
        .i_ready               (o_note.ready),
        .o_note_index          (o_note.note_index),
        .o_pitch_class         (o_note.pitch_class),
        .o_semitone_above_root (o_note.semitone_above_root),
        .o_note_freq           (o_note.note_freq),
        .o_last_note           (o_note.last_note)
    );

endmodule
